@@ rtl/vml_pkg.sv @@
`timescale 1ns / 1ps
package vml_pkg;

   localparam int MAX_COMPONENTS = 4;
   localparam int COMP_W         = 32;
   localparam int SQRT_STEPS     = 32;
   localparam int QUO_W          = 34;
   localparam int LANE_LAT       = 2 + QUO_W;
   localparam int FRONT_LAT      = 4;
   localparam int VLD_N          = FRONT_LAT + SQRT_STEPS + LANE_LAT;

   typedef struct packed {
      logic                                op;
      logic [COMP_W-1:0]                   tgt;
      logic [MAX_COMPONENTS-1:0][COMP_W-1:0] comp;
      logic [2:0]                          n;
      logic                                carry;
   } pay_type;

   typedef struct packed {
      pay_type     base;
      logic [32:0] len;
      logic        scale;
   } post_type;

   function automatic logic [COMP_W-1:0] mag32(input logic [COMP_W-1:0] v);
      mag32 = v[COMP_W-1] ? (~v + 32'd1) : v;
   endfunction

endpackage

@@ rtl/vml_sqrt.sv @@
`timescale 1ns / 1ps
module vml_sqrt (
   input  logic        clock,
   input  logic        adv,
   input  logic [63:0] rad,
   output logic [31:0] root
);

   logic [34:0] rem_ff  [vml_pkg::SQRT_STEPS];
   logic [31:0] root_ff [vml_pkg::SQRT_STEPS];
   logic [63:0] rad_ff  [vml_pkg::SQRT_STEPS];

   for (genvar k = 0; k < vml_pkg::SQRT_STEPS; k++) begin : g_step
      logic [34:0] rem_prev, rem_sh, trial, rem_in;
      logic [31:0] root_prev, root_in;
      logic [63:0] rad_prev;

      if (k == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = rad;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign rad_prev  = rad_ff[k-1];
      end

      // bring down two radicand bits, try root*4+1
      always_comb begin
         rem_sh = {rem_prev[32:0], rad_prev[63:62]};
         trial  = {1'b0, root_prev, 2'b01};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_prev[30:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_prev[30:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            rad_ff[k]  <= {rad_prev[61:0], 2'b00};
         end
      end
   end

   assign root = root_ff[vml_pkg::SQRT_STEPS-1];

endmodule

@@ rtl/vml_lane.sv @@
`timescale 1ns / 1ps
module vml_lane (
   input  logic                      clock,
   input  logic                      adv,
   input  logic [31:0]               mag,
   input  logic [31:0]               tmag,
   input  logic [32:0]               len,
   output logic [vml_pkg::QUO_W-1:0] quo,
   output logic                      ovf
);

   logic [63:0] prod_ff;
   logic [32:0] lena_ff;
   logic [63:0] dvd;
   logic [29:0] hi;

   logic [32:0]               rem_ff [vml_pkg::QUO_W+1];
   logic [33:0]               low_ff [vml_pkg::QUO_W+1];
   logic [32:0]               len_ff [vml_pkg::QUO_W+1];
   logic [vml_pkg::QUO_W-1:0] quo_ff [vml_pkg::QUO_W+1];
   logic                      ovf_ff [vml_pkg::QUO_W+1];

   // round to nearest: add half the divisor up front
   assign dvd = prod_ff + {32'd0, lena_ff[32:1]};
   assign hi  = dvd[63:34];

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff   <= mag * tmag;
         lena_ff   <= len;
         rem_ff[0] <= {3'd0, hi};
         low_ff[0] <= dvd[33:0];
         len_ff[0] <= lena_ff;
         quo_ff[0] <= '0;
         ovf_ff[0] <= ({3'd0, hi} >= lena_ff);
      end
   end

   for (genvar j = 1; j <= vml_pkg::QUO_W; j++) begin : g_iter
      logic [33:0]               r2;
      logic [32:0]               rem_in;
      logic [vml_pkg::QUO_W-1:0] quo_in;

      always_comb begin
         r2 = {rem_ff[j-1], low_ff[j-1][33]};
         if (r2 >= {1'b0, len_ff[j-1]}) begin
            rem_in = 33'(r2 - {1'b0, len_ff[j-1]});
            quo_in = {quo_ff[j-1][vml_pkg::QUO_W-2:0], 1'b1};
         end else begin
            rem_in = r2[32:0];
            quo_in = {quo_ff[j-1][vml_pkg::QUO_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[j] <= rem_in;
            low_ff[j] <= {low_ff[j-1][32:0], 1'b0};
            len_ff[j] <= len_ff[j-1];
            quo_ff[j] <= quo_in;
            ovf_ff[j] <= ovf_ff[j-1];
         end
      end
   end

   assign quo = quo_ff[vml_pkg::QUO_W];
   assign ovf = ovf_ff[vml_pkg::QUO_W];

endmodule

@@ rtl/vector_magnitude_limit.sv @@
`timescale 1ns / 1ps
// Clamps or sets the Euclidean length of a vector of up to four signed Q16.16
// components. One word is accepted every cycle; the whole pipeline stalls only
// while a result waits at the output. Each result passes 4 front stages for
// squares and sums, 32 stages of the one-bit-per-stage square root, 36 stages
// of the per-lane multiply and radix-2 divider, and the output register. With
// every result taken, the sustained rate is one word per cycle. csr_wdata sets
// the number of components in use (0 acts as 1, above 4 acts as 4); write it
// only while the pipeline is empty.
module vector_magnitude_limit (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wen,
   input  logic [2:0]   csr_wdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // target_magnitude, comp_x, comp_y, comp_z, comp_w
   input  logic [159:0] req_tdata,
   // opcode
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_x, out_y, out_z, out_w, input_length, was_scaled, zero_vector,
   // saturated, zero fill
   output logic [167:0] rsp_tdata
);

   localparam int NL = vml_pkg::MAX_COMPONENTS;

   logic        adv;
   logic [2:0]  vlen_ff;
   logic [2:0]  n_cl;
   logic [vml_pkg::VLD_N-1:0] vld_ff;
   logic        rsp_valid_ff;
   logic [167:0] rsp_data_ff, rsp_data_in;

   vml_pkg::pay_type  pay0_ff, pay1_ff, pay2_ff, pay3_ff, pay3_in;
   vml_pkg::pay_type  paya_ff [vml_pkg::SQRT_STEPS];
   vml_pkg::post_type payb_ff [vml_pkg::LANE_LAT];
   vml_pkg::post_type post_in, fin;

   logic [63:0] sq1_ff [NL];
   logic [64:0] ps2_ff [2];
   logic [65:0] sum3_ext;
   logic [64:0] sum3_ff;
   logic [31:0] root;

   logic [vml_pkg::QUO_W-1:0] quo [NL];
   logic [NL-1:0]             ovf;

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      if (vlen_ff == 3'd0)
         n_cl = 3'd1;
      else if (vlen_ff > 3'(NL))
         n_cl = 3'(NL);
      else
         n_cl = vlen_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vlen_ff      <= 3'(NL);
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wen)
            vlen_ff <= csr_wdata;
         if (adv) begin
            vld_ff       <= {vld_ff[vml_pkg::VLD_N-2:0], req_tvalid};
            rsp_valid_ff <= vld_ff[vml_pkg::VLD_N-1];
         end
      end
   end

   // sum of squares overflowing 64 bits marks a length of 2^32
   assign sum3_ext = {1'b0, ps2_ff[0]} + {1'b0, ps2_ff[1]};

   always_comb begin
      pay3_in       = pay2_ff;
      pay3_in.carry = sum3_ext[64];
   end

   // front: capture, square each lane, two-level sum
   always_ff @(posedge clock) begin
      if (adv) begin
         pay0_ff.op    <= req_tuser;
         pay0_ff.tgt   <= req_tdata[31:0];
         pay0_ff.comp  <= req_tdata[159:32];
         pay0_ff.n     <= n_cl;
         pay0_ff.carry <= 1'b0;
         pay1_ff       <= pay0_ff;
         pay2_ff       <= pay1_ff;
         pay3_ff       <= pay3_in;
         ps2_ff[0]     <= {1'b0, sq1_ff[0]} + {1'b0, sq1_ff[1]};
         ps2_ff[1]     <= {1'b0, sq1_ff[2]} + {1'b0, sq1_ff[3]};
         sum3_ff       <= sum3_ext[64:0];
      end
   end

   for (genvar i = 0; i < NL; i++) begin : g_sq
      logic [31:0] m;
      assign m = vml_pkg::mag32(pay0_ff.comp[i]);
      always_ff @(posedge clock) begin
         if (adv)
            sq1_ff[i] <= (3'(i) < pay0_ff.n) ? m * m : 64'd0;
      end
   end

   vml_sqrt u_sqrt (
      .clock (clock),
      .adv   (adv),
      .rad   (sum3_ff[63:0]),
      .root  (root)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         paya_ff[0] <= pay3_ff;
         for (int k = 1; k < vml_pkg::SQRT_STEPS; k++)
            paya_ff[k] <= paya_ff[k-1];
         payb_ff[0] <= post_in;
         for (int k = 1; k < vml_pkg::LANE_LAT; k++)
            payb_ff[k] <= payb_ff[k-1];
      end
   end

   always_comb begin
      post_in.base  = paya_ff[vml_pkg::SQRT_STEPS-1];
      post_in.len   = post_in.base.carry ? 33'h1_0000_0000 : {1'b0, root};
      post_in.scale = post_in.base.op ||
                      ($signed({1'b0, post_in.len}) >
                       $signed({{2{post_in.base.tgt[31]}}, post_in.base.tgt}));
   end

   for (genvar i = 0; i < NL; i++) begin : g_lane
      vml_lane u_lane (
         .clock (clock),
         .adv   (adv),
         .mag   (vml_pkg::mag32(post_in.base.comp[i])),
         .tmag  (vml_pkg::mag32(post_in.base.tgt)),
         .len   (post_in.len),
         .quo   (quo[i]),
         .ovf   (ovf[i])
      );
   end

   // merge: pick pass-through or scaled, saturate, gather flags
   assign fin = payb_ff[vml_pkg::LANE_LAT-1];

   always_comb begin
      logic [3:0][31:0] res;
      logic sat, rneg, big;
      res = '0;
      sat = 1'b0;
      for (int i = 0; i < NL; i++) begin
         rneg = 1'b0;
         big  = 1'b0;
         if (3'(i) < fin.base.n) begin
            if (!fin.scale) begin
               res[i] = fin.base.comp[i];
            end else begin
               rneg = (fin.base.comp[i][31] != fin.base.tgt[31]) &&
                      (quo[i] != '0 || ovf[i]);
               if (rneg) begin
                  big    = ovf[i] || quo[i] > 34'h0_8000_0000;
                  res[i] = big ? 32'h8000_0000 : (~quo[i][31:0] + 32'd1);
               end else begin
                  big    = ovf[i] || quo[i] > 34'h0_7FFF_FFFF;
                  res[i] = big ? 32'h7FFF_FFFF : quo[i][31:0];
               end
               sat = sat | big;
            end
         end
      end
      if (fin.len == 33'd0)
         rsp_data_in = {4'd0, 3'b010, 33'd0, 128'd0};
      else
         rsp_data_in = {4'd0, sat, 1'b0, fin.scale, fin.len, res};
   end

   always_ff @(posedge clock) begin
      if (adv)
         rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   a_zero_clean : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[162] |-> !rsp_tdata[161] && !rsp_tdata[163])
      else $error("zero vector result carries scale flags");
   a_sat_scaled : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[163] |-> rsp_tdata[161])
      else $error("saturation without rescale");
   a_hold_word : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result word lost");
   a_len_carry : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[160] |-> rsp_tdata[159:128] == 32'd0)
      else $error("length above 2^32 is malformed");
`endif

endmodule
